### rtl/core/dre_pkg.sv
// ----------------------------------------------------------------------------
// dre_pkg
// Shared sizes, row type, result struct and the masked row compare used by
// the duplicate row eliminator.
// ----------------------------------------------------------------------------
package dre_pkg;

    localparam int COLS         = 8;
    localparam int MAX_DISTINCT = 256;
    localparam int MASK_W       = 8;
    localparam int USED_COLS    = (COLS < MASK_W) ? COLS : MASK_W;
    localparam int WORD_W       = 32;
    localparam int ROW_W        = USED_COLS * WORD_W;
    localparam int ADDR_W       = $clog2(MAX_DISTINCT);
    localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);
    localparam int DROP_W       = 16;

    localparam logic [MASK_W-1:0] MASK_RESET = {MASK_W{1'b1}};
    localparam logic [DROP_W-1:0] DROP_MAX   = {DROP_W{1'b1}};
    localparam logic [CNT_W-1:0]  STORE_CAP  = CNT_W'(MAX_DISTINCT);

    typedef logic [USED_COLS-1:0][WORD_W-1:0] row_t;

    typedef struct packed {
        logic              keep_row;
        logic [DROP_W-1:0] dropped_total;
        logic              store_full;
        logic              set_done;
    } result_t;

    // True when the rows agree on every column selected by the mask.
    function automatic logic row_match(input row_t stored, input row_t row,
                                       input logic [MASK_W-1:0] mask);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < USED_COLS; k++) begin
            if (mask[k] && (stored[k] != row[k])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

### rtl/core/dre_row_ram.sv
// ----------------------------------------------------------------------------
// dre_row_ram
// Simple dual-port synchronous RAM, one write port and one registered read
// port whose data appears in the cycle after the read is enabled.
// ----------------------------------------------------------------------------
module dre_row_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/dre_scan.sv
// ----------------------------------------------------------------------------
// dre_scan
// Scan sequencer: holds the current row, streams the stored rows out of the
// row RAM one per cycle, compares them and decides keep or drop. Owns the
// distinct and dropped counters and appends new rows to the RAM.
// ----------------------------------------------------------------------------
module dre_scan
    import dre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  row_t              row_in,
    input  logic              last_in,
    input  logic [MASK_W-1:0] mask,
    input  logic              slot_free,
    input  row_t              rd_data,
    output logic              idle,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output row_t              wr_data,
    output logic              res_valid,
    output result_t           res
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic              cmp_last_reg, cmp_last_next;
    logic              dup_reg, dup_next;
    row_t              row_reg;
    logic              last_reg;

    logic              hit;
    logic              is_full;
    logic [DROP_W-1:0] drop_inc;

    assign hit      = row_match(rd_data, row_reg, mask);
    assign is_full  = (count_reg == STORE_CAP);
    assign drop_inc = (drop_reg == DROP_MAX) ? drop_reg : drop_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        dup_next       = dup_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        res_valid      = 1'b0;
        res.keep_row      = !dup_reg;
        res.dropped_total = dup_reg ? drop_inc : drop_reg;
        res.store_full    = !dup_reg && is_full;
        res.set_done      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    issue_next = '0;
                    dup_next   = 1'b0;
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_valid_reg && (hit || cmp_last_reg))
                begin
                    // stop issuing; any read still in flight is ignored
                    dup_next   = hit;
                    state_next = ST_DECIDE;
                end
                else if (issue_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_last_next  = (CNT_W'(issue_reg + 1'b1) == count_reg);
                end
            end
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    res_valid = 1'b1;
                    if (dup_reg)
                    begin
                        drop_next = drop_inc;
                    end
                    else if (!is_full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        count_next = '0;
                        drop_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = row_reg;
    assign idle    = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            dup_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            dup_reg       <= dup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && idle)
        begin
            row_reg  <= row_in;
            last_reg <= last_in;
        end
    end

endmodule

### rtl/core/duplicate_row_eliminator.sv
// ----------------------------------------------------------------------------
// duplicate_row_eliminator
// Keeps the first row of each kind in a data set and drops later repeats.
// ----------------------------------------------------------------------------
// One row is worked on at a time. After a row is accepted, every stored
// distinct row of the current set is read from the row RAM, one whole row per
// cycle, and compared on the columns selected by column_mask; the scan stops
// at the first match. The time from one acceptance to the next grows with
// the number of rows stored so far; the single RAM read port sets this. A
// row kept while the store is full is not written to it. The result waits in
// an output register, so the next row may be accepted while it is not yet
// taken. A row marked final_row is judged normally, then the store and the
// dropped count are emptied. column_mask is written through the cfg channel,
// always ready, and should only change between transactions.
// ----------------------------------------------------------------------------
module duplicate_row_eliminator
    import dre_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [MASK_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [WORD_W-1:0] value_0,
    input  logic signed [WORD_W-1:0] value_1,
    input  logic signed [WORD_W-1:0] value_2,
    input  logic signed [WORD_W-1:0] value_3,
    input  logic signed [WORD_W-1:0] value_4,
    input  logic signed [WORD_W-1:0] value_5,
    input  logic signed [WORD_W-1:0] value_6,
    input  logic signed [WORD_W-1:0] value_7,
    input  logic                     final_row,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     keep_row,
    output logic [DROP_W-1:0]        dropped_total,
    output logic                     store_full,
    output logic                     set_done
);

    logic [MASK_W-1:0] mask_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic [WORD_W-1:0] values [MASK_W];
    row_t              row_in;
    row_t              rd_data;
    row_t              wr_data;
    logic              idle;
    logic              start;
    logic              slot_free;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              res_valid;
    result_t           res;

    assign values[0] = value_0;
    assign values[1] = value_1;
    assign values[2] = value_2;
    assign values[3] = value_3;
    assign values[4] = value_4;
    assign values[5] = value_5;
    assign values[6] = value_6;
    assign values[7] = value_7;

    always_comb
    begin
        for (int k = 0; k < USED_COLS; k++) begin
            row_in[k] = values[k];
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = idle;
    assign start     = in_valid && idle;
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_valid)
        begin
            mask_reg <= cfg_data;
        end
    end

    dre_row_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (MAX_DISTINCT)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dre_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .row_in    (row_in),
        .last_in   (final_row),
        .mask      (mask_reg),
        .slot_free (slot_free),
        .rd_data   (rd_data),
        .idle      (idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold the result until taken; a new one only lands when the slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign keep_row      = out_reg.keep_row;
    assign dropped_total = out_reg.dropped_total;
    assign store_full    = out_reg.store_full;
    assign set_done      = out_reg.set_done;

endmodule

### rtl/core/dre_checker.sv
// ----------------------------------------------------------------------------
// dre_checker
// Port-level checks for the duplicate row eliminator, bound to the top level.
// ----------------------------------------------------------------------------
module dre_checker
    import dre_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              keep_row,
    input logic [DROP_W-1:0] dropped_total,
    input logic              store_full,
    input logic              set_done
);

    logic set_start_reg;

    // mark that the next result opens a fresh set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_start_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            set_start_reg <= set_done;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid dropped before acceptance");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(keep_row)
            && $stable(dropped_total) && $stable(set_done))
        else $error("result changed while stalled");

    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !keep_row |-> dropped_total != '0)
        else $error("dropped row with zero dropped count");

    a_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_full |-> keep_row)
        else $error("store_full on a dropped row");

    a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && set_start_reg |-> keep_row && dropped_total == '0)
        else $error("first row of a set not kept");

endmodule

bind duplicate_row_eliminator dre_checker u_dre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .keep_row      (keep_row),
    .dropped_total (dropped_total),
    .store_full    (store_full),
    .set_done      (set_done)
);
